/* hw/rtl/point_in_polygon_test_defines.svh */
// Assertion macros for the point-in-polygon tester.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH
`ifndef SYNTHESIS
// check that is switched off while reset is high
`define PIP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pip assertion failed");
// check that also covers the reset cycles
`define PIP_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pip reset assertion failed");
`else
`define PIP_ASSERT(lbl, clk, rst, prop)
`define PIP_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* hw/rtl/pip_pkg.sv */
// Shared sizes, codes and sequencer states of the point-in-polygon tester.
// No dependencies; imported by point_in_polygon_test.
package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;

  localparam int IDX_W  = $clog2(MAX_VERTICES);
  localparam int CNT_W  = IDX_W + 1;
  localparam int DIFF_W = COORD_WIDTH + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int WIND_W = (CNT_W + 1 > 8) ? CNT_W + 1 : 8;
  localparam int PADDR_W = 3;

  localparam logic signed [WIND_W-1:0] WIND_HI = WIND_W'(127);
  localparam logic signed [WIND_W-1:0] WIND_LO = WIND_W'(-128);

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_TEST   = 2'd2;

  localparam logic [PADDR_W-1:0] ADDR_FILL_MODE = PADDR_W'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_DIFF,
    ST_MUL1,
    ST_MUL2,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

/* hw/rtl/point_in_polygon_test.sv */
// Point-in-polygon tester: vertex store, edge sequencer, shared multiplier.
// Depends on pip_pkg and point_in_polygon_test_defines.svh.
//
// Sequence: a clear, an append or an unused action code goes straight to the
// result state. A test point walks the edges of the polygon and stops early
// when an edge is touched: each edge needs one vertex read, a difference step,
// two passes through the single 17x17 multiplier for the cross product terms,
// and a classify step. An empty polygon goes straight to the result state. A
// finished result waits in the output register, so the next beat may be taken
// while it is still stalled.
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         action,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_x,
  input  logic signed [pip_pkg::COORD_WIDTH-1:0] coord_y,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               inside_res,
  output logic                               on_boundary,
  output logic signed [7:0]                  winding,
  output logic                               status,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pip_pkg::PADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  import pip_pkg::*;

  state_t state, state_next;

  logic fill_mode;
  logic [CNT_W-1:0] vcount;

  logic [2*COORD_WIDTH-1:0] vmem [MAX_VERTICES];
  logic [2*COORD_WIDTH-1:0] rd_data;
  logic                     rd_en;
  logic [IDX_W-1:0]         rd_addr;
  logic                     wr_en;

  logic signed [COORD_WIDTH-1:0] px, py, ox, oy, dx, dy;
  logic signed [COORD_WIDTH-1:0] rd_x, rd_y;
  logic signed [DIFF_W-1:0] ax, ay, bx, by;
  logic signed [DIFF_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, p1, p2;
  logic signed [SUM_W-1:0]  cross_prod;

  logic [IDX_W-1:0] nxt, nxt_wrap;
  logic [CNT_W-1:0] nxt_inc;
  logic [CNT_W-1:0] edge_cnt;
  logic             edge_last;

  logic signed [WIND_W-1:0] wind;
  logic parity, boundary, status_flag;

  logic in_acc, out_load, full;
  logic s_pos, s_neg, opp_x, opp_y, on_seg, up, down, touch;
  logic [DIFF_W-1:0] ax_mag, ay_mag, bx_mag, by_mag;

  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-1:0] r;
    r = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return r;
  endfunction

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_FILL_MODE) ? {31'd0, fill_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr == ADDR_FILL_MODE) begin
      fill_mode <= pwdata[0];
    end
  end

  // ---------------- handshake and control ----------------
  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (vcount == CNT_W'(MAX_VERTICES));
  assign wr_en    = in_acc && action == ACT_APPEND && !full;

  assign nxt_inc   = CNT_W'({1'b0, nxt} + 1'b1);
  assign nxt_wrap  = (nxt_inc == vcount) ? '0 : nxt_inc[IDX_W-1:0];
  assign edge_last = (CNT_W'(edge_cnt + 1'b1) == vcount);

  // ---------------- edge classification ----------------
  assign rd_x  = $signed(rd_data[2*COORD_WIDTH-1:COORD_WIDTH]);
  assign rd_y  = $signed(rd_data[COORD_WIDTH-1:0]);

  assign mul_a = (state == ST_MUL1) ? ax : bx;
  assign mul_b = (state == ST_MUL1) ? by : ay;
  assign prod  = mul_a * mul_b;

  assign cross_prod = SUM_W'(p1) - SUM_W'(p2);
  assign s_neg = cross_prod[SUM_W-1];
  assign s_pos = !s_neg && (cross_prod != '0);

  assign ax_mag = mag(ax);
  assign ay_mag = mag(ay);
  assign bx_mag = mag(bx);
  assign by_mag = mag(by);

  // collinear case: point behind the origin, past the end, or on the segment
  assign opp_x  = (ax != '0) && (bx != '0) && (ax[DIFF_W-1] != bx[DIFF_W-1]);
  assign opp_y  = (ay != '0) && (by != '0) && (ay[DIFF_W-1] != by[DIFF_W-1]);
  assign on_seg = (bx_mag <= ax_mag) && (by_mag <= ay_mag);
  assign touch  = !s_pos && !s_neg && !opp_x && !opp_y && on_seg;
  assign up     = s_pos && (py > oy) && (py <= dy);
  assign down   = s_neg && (py > dy) && (py <= oy);

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = nxt_wrap;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        rd_addr = '0;
        if (in_acc) begin
          if (action == ACT_TEST && vcount != '0) begin
            rd_en      = 1'b1;
            state_next = ST_FIRST;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_FIRST: begin
        rd_en      = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_EVAL;
      ST_EVAL: begin
        if (touch || edge_last) begin
          state_next = ST_DONE;
        end else begin
          rd_en      = 1'b1;
          state_next = ST_DIFF;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // ---------------- vertex store ----------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[vcount[IDX_W-1:0]] <= {coord_x, coord_y};
    end
    if (rd_en) begin
      rd_data <= vmem[rd_addr];
    end
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (in_acc && action == ACT_CLEAR) begin
        vcount <= '0;
      end else if (wr_en) begin
        vcount <= CNT_W'(vcount + 1'b1);
      end
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      px          <= coord_x;
      py          <= coord_y;
      wind        <= '0;
      parity      <= 1'b0;
      boundary    <= 1'b0;
      status_flag <= (action == ACT_APPEND) && full;
      nxt         <= '0;
      edge_cnt    <= '0;
    end
    unique case (state)
      ST_FIRST: begin
        ox  <= rd_x;
        oy  <= rd_y;
        nxt <= nxt_wrap;
      end
      ST_DIFF: begin
        dx <= rd_x;
        dy <= rd_y;
        ax <= DIFF_W'(rd_x) - DIFF_W'(ox);
        ay <= DIFF_W'(rd_y) - DIFF_W'(oy);
        bx <= DIFF_W'(px) - DIFF_W'(ox);
        by <= DIFF_W'(py) - DIFF_W'(oy);
      end
      ST_MUL1: p1 <= prod;
      ST_MUL2: p2 <= prod;
      ST_EVAL: begin
        if (touch) begin
          boundary <= 1'b1;
        end else if (up) begin
          wind   <= WIND_W'(wind + 1'b1);
          parity <= !parity;
        end else if (down) begin
          wind   <= WIND_W'(wind - 1'b1);
          parity <= !parity;
        end
        ox       <= dx;
        oy       <= dy;
        nxt      <= nxt_wrap;
        edge_cnt <= CNT_W'(edge_cnt + 1'b1);
      end
      default: ;
    endcase
    if (out_load) begin
      inside_res  <= boundary || (fill_mode ? (wind != '0) : parity);
      on_boundary <= boundary;
      status      <= status_flag;
      if (wind > WIND_HI) begin
        winding <= 8'sd127;
      end else if (wind < WIND_LO) begin
        winding <= -8'sd128;
      end else begin
        winding <= wind[7:0];
      end
    end
  end

  // ---------------- checks ----------------
  `PIP_ASSERT(a_count_bound, clk, rst, vcount <= CNT_W'(MAX_VERTICES))
  `PIP_ASSERT(a_edge_bound, clk, rst, (state == ST_EVAL) |-> (edge_cnt < vcount))
  `PIP_ASSERT(a_test_walk, clk, rst, (in_acc && action == ACT_TEST && vcount != '0) |=> (state == ST_FIRST))
  `PIP_ASSERT(a_full_drop, clk, rst, (in_acc && action == ACT_APPEND && full) |=> (full && status_flag))
  `PIP_ASSERT(a_result_src, clk, rst, $rose(out_valid) |-> ($past(state) == ST_DONE))
  `PIP_ASSERT_RST(a_reset_out, clk, rst |=> !out_valid)

endmodule
